// ===== src/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared defaults and sizing constants for the sample statistics accumulator.
// ----------------------------------------------------------------------------
package ssa_pkg;

	// default sample width (signed fixed point) and count bound
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int MAX_SAMPLES_DEF  = 65536;

	// count width that holds the default bound itself
	localparam int COUNT_WIDTH_DEF  = $clog2(MAX_SAMPLES_DEF + 1);

	// entries between the front end and the back end
	localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/ssa_if.sv =====
// ----------------------------------------------------------------------------
// ssa_if
// Valid/ready channel interfaces for samples in and statistics results out.
// ----------------------------------------------------------------------------
interface ssa_in_if #(
	parameter int SAMPLE_WIDTH = ssa_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_x;
	logic signed [SAMPLE_WIDTH-1:0] sample_y;
	logic                           last_sample;

	modport source (output valid, sample_x, sample_y, last_sample, input ready);
	modport sink (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

interface ssa_out_if #(
	parameter int SAMPLE_WIDTH = ssa_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = ssa_pkg::COUNT_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] lowest_x;
	logic signed [SAMPLE_WIDTH-1:0] highest_x;
	logic signed [SAMPLE_WIDTH-1:0] lowest_y;
	logic signed [SAMPLE_WIDTH-1:0] highest_y;
	logic [COUNT_WIDTH-1:0]         sample_count;
	logic signed [SAMPLE_WIDTH-1:0] mean_y;
	logic [SAMPLE_WIDTH-1:0]        rms_y;
	logic                           stats_ready;
	logic                           count_overflow;

	modport source (output valid, lowest_x, highest_x, lowest_y, highest_y, sample_count,
		mean_y, rms_y, stats_ready, count_overflow, input ready);
	modport sink (input valid, lowest_x, highest_x, lowest_y, highest_y, sample_count,
		mean_y, rms_y, stats_ready, count_overflow, output ready);
endinterface

// ===== src/ssa_front.sv =====
// ----------------------------------------------------------------------------
// ssa_front
// Accepts samples, tracks extremes and count, squares y, accumulates the sums
// and pushes one entry per sample into the queue.
// ----------------------------------------------------------------------------
module ssa_front #(
	parameter int SAMPLE_WIDTH = ssa_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_SAMPLES  = ssa_pkg::MAX_SAMPLES_DEF,
	localparam int SW  = SAMPLE_WIDTH,
	localparam int CW  = $clog2(MAX_SAMPLES + 1),
	localparam int SYW = SW + CW,
	localparam int SQW = 2 * SW + CW - 2,
	localparam int EW  = 4 * SW + CW + 2 + SYW + SQW
) (
	input  logic          clk,
	input  logic          arst_n,
	ssa_in_if.sink        samples,
	output logic          push,
	output logic [EW-1:0] push_data,
	input  logic          full
);

	// running extremes and count for the open set
	logic signed [SW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [CW-1:0]        count_q;
	logic                 ovf_q;

	// stage 1: sample after extremes update and squaring
	logic                 valid_s1;
	logic signed [SW-1:0] min_x_s1, max_x_s1, min_y_s1, max_y_s1;
	logic [CW-1:0]        count_s1;
	logic                 ovf_s1;
	logic                 last_s1;
	logic signed [SW-1:0] add_y_s1;
	logic [2*SW-2:0]      sq_s1;

	// accumulated sums
	logic signed [SYW-1:0] sum_y_q;
	logic [SQW-1:0]        sum_sq_q;

	logic                  accept;
	logic                  first;
	logic                  counted;
	logic signed [SW-1:0]  min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
	logic [CW-1:0]         count_nxt;
	logic signed [2*SW-1:0] prod;
	logic signed [SYW-1:0] sum_y_nxt;
	logic [SQW-1:0]        sum_sq_nxt;

	// handshake: stage 1 frees up whenever its entry goes into the queue
	assign push          = valid_s1 && !full;
	assign samples.ready = !valid_s1 || !full;
	assign accept        = samples.valid && samples.ready;

	// extremes, count and overflow of the incoming sample
	always_comb begin
		first     = (count_q == '0);
		counted   = (count_q < CW'(MAX_SAMPLES));
		min_x_nxt = (first || samples.sample_x < min_x_q) ? samples.sample_x : min_x_q;
		max_x_nxt = (first || samples.sample_x > max_x_q) ? samples.sample_x : max_x_q;
		min_y_nxt = (first || samples.sample_y < min_y_q) ? samples.sample_y : min_y_q;
		max_y_nxt = (first || samples.sample_y > max_y_q) ? samples.sample_y : max_y_q;
		count_nxt = counted ? count_q + 1'b1 : count_q;
		prod      = samples.sample_y * samples.sample_y;
	end

	// extremes hold payload only, the count decides when they are reloaded
	always_ff @(posedge clk) begin
		if (accept) begin
			min_x_q  <= min_x_nxt;
			max_x_q  <= max_x_nxt;
			min_y_q  <= min_y_nxt;
			max_y_q  <= max_y_nxt;
			min_x_s1 <= min_x_nxt;
			max_x_s1 <= max_x_nxt;
			min_y_s1 <= min_y_nxt;
			max_y_s1 <= max_y_nxt;
			count_s1 <= count_nxt;
			ovf_s1   <= ovf_q || !counted;
			last_s1  <= samples.last_sample;
			add_y_s1 <= counted ? samples.sample_y : '0;
			sq_s1    <= counted ? prod[2*SW-2:0] : '0;
		end
	end

	// count, overflow flag and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (samples.last_sample) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_nxt;
					ovf_q   <= ovf_q || !counted;
				end
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage 2: sums, cleared after the last sample of a set
	assign sum_y_nxt  = sum_y_q + SYW'(add_y_s1);
	assign sum_sq_nxt = sum_sq_q + SQW'(sq_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_y_q  <= '0;
			sum_sq_q <= '0;
		end else if (push) begin
			if (last_s1) begin
				sum_y_q  <= '0;
				sum_sq_q <= '0;
			end else begin
				sum_y_q  <= sum_y_nxt;
				sum_sq_q <= sum_sq_nxt;
			end
		end
	end

	// queue entry
	assign push_data = {min_x_s1, max_x_s1, min_y_s1, max_y_s1, count_s1, ovf_s1, last_s1,
		sum_y_nxt, sum_sq_nxt};

endmodule

// ===== src/ssa_queue.sv =====
// ----------------------------------------------------------------------------
// ssa_queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ssa_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ssa_pkg::QUEUE_DEPTH,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    fill_q;

	assign full     = (fill_q == NW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/ssa_div.sv =====
// ----------------------------------------------------------------------------
// ssa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssa_div #(
	parameter int NUM_WIDTH = 47,
	parameter int DEN_WIDTH = 17,
	localparam int CNTW = $clog2(NUM_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_WIDTH-1:0] num,
	input  logic [DEN_WIDTH-1:0] den,
	output logic                 done,
	output logic [NUM_WIDTH-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNTW-1:0]      cnt_q;
	logic [NUM_WIDTH-1:0] num_q;
	logic [DEN_WIDTH-1:0] rem_q;
	logic [DEN_WIDTH-1:0] den_q;

	logic [DEN_WIDTH:0]   shifted;
	logic [DEN_WIDTH:0]   diff;
	logic                 ge;

	// one shift-and-subtract step
	always_comb begin
		shifted = {rem_q, num_q[NUM_WIDTH-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	// dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_WIDTH-2:0], ge};
			rem_q <= ge ? diff[DEN_WIDTH-1:0] : shifted[DEN_WIDTH-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NUM_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

// ===== src/ssa_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssa_sqrt
// Floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ssa_sqrt #(
	parameter int ROOT_WIDTH = 16,
	localparam int CNTW = (ROOT_WIDTH > 1) ? $clog2(ROOT_WIDTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*ROOT_WIDTH-1:0] rad,
	output logic                    done,
	output logic [ROOT_WIDTH-1:0]   root
);

	localparam int RW = ROOT_WIDTH;

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [2*RW-1:0] rad_q;
	logic [RW-1:0]   root_q;
	logic [RW+1:0]   rem_q;

	logic [RW+3:0]   shifted;
	logic [RW+3:0]   trial;
	logic [RW+3:0]   diff;
	logic            ge;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		shifted = {rem_q, rad_q[2*RW-1:2*RW-2]};
		trial   = (RW + 4)'({root_q, 2'b01});
		diff    = shifted - trial;
		ge      = (shifted >= trial);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			root_q <= {root_q[RW-2:0], ge};
			rem_q  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== src/ssa_back.sv =====
// ----------------------------------------------------------------------------
// ssa_back
// Drains the queue into the output register; for the last sample of a set it
// sequences the mean and mean-square divisions and the square root.
// ----------------------------------------------------------------------------
module ssa_back #(
	parameter int SAMPLE_WIDTH = ssa_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_SAMPLES  = ssa_pkg::MAX_SAMPLES_DEF,
	localparam int SW  = SAMPLE_WIDTH,
	localparam int CW  = $clog2(MAX_SAMPLES + 1),
	localparam int SYW = SW + CW,
	localparam int SQW = 2 * SW + CW - 2,
	localparam int EW  = 4 * SW + CW + 2 + SYW + SQW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [EW-1:0] pop_data,
	input  logic          empty,
	output logic          pop,
	ssa_out_if.source     results
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MEAN = 5'b00010,
		ST_MSQ  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	// queue head fields
	logic signed [SW-1:0]  h_min_x, h_max_x, h_min_y, h_max_y;
	logic [CW-1:0]         h_count;
	logic                  h_ovf;
	logic                  h_last;
	logic signed [SYW-1:0] h_sum_y;
	logic [SQW-1:0]        h_sum_sq;
	logic [SYW-1:0]        sum_mag;

	assign {h_min_x, h_max_x, h_min_y, h_max_y, h_count, h_ovf, h_last, h_sum_y, h_sum_sq}
		= pop_data;
	assign sum_mag = h_sum_y[SYW-1] ? SYW'(-h_sum_y) : SYW'(h_sum_y);

	// held copy of the last sample's entry
	logic signed [SW-1:0] k_min_x_q, k_max_x_q, k_min_y_q, k_max_y_q;
	logic [CW-1:0]        k_count_q;
	logic                 k_ovf_q;
	logic                 k_neg_q;
	logic [SQW-1:0]       k_sum_sq_q;
	logic signed [SW-1:0] k_mean_q;
	logic [SW-1:0]        k_rms_q;

	// output register
	logic                 out_valid_q;
	logic signed [SW-1:0] o_min_x_q, o_max_x_q, o_min_y_q, o_max_y_q;
	logic [CW-1:0]        o_count_q;
	logic signed [SW-1:0] o_mean_q;
	logic [SW-1:0]        o_rms_q;
	logic                 o_stats_q;
	logic                 o_ovf_q;

	// arithmetic units
	logic            div_start, div_done;
	logic [SQW-1:0]  div_num, div_quo;
	logic [CW-1:0]   div_den;
	logic            sqrt_start, sqrt_done;
	logic [SW-1:0]   sqrt_root;

	logic            out_free;
	logic            take_last;
	logic            load_plain;
	logic            load_stats;

	// control decode
	always_comb begin
		out_free   = !out_valid_q || results.ready;
		take_last  = (state_q == ST_IDLE) && !empty && h_last;
		load_plain = (state_q == ST_IDLE) && !empty && !h_last && out_free;
		load_stats = (state_q == ST_EMIT) && out_free;
		pop        = take_last || load_plain;
		div_start  = take_last || ((state_q == ST_MEAN) && div_done);
		div_num    = (state_q == ST_IDLE) ? SQW'(sum_mag) : k_sum_sq_q;
		div_den    = (state_q == ST_IDLE) ? h_count : k_count_q;
		sqrt_start = (state_q == ST_MSQ) && div_done;
	end

	ssa_div #(
		.NUM_WIDTH(SQW),
		.DEN_WIDTH(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	ssa_sqrt #(
		.ROOT_WIDTH(SW)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.rad   (div_quo[2*SW-1:0]),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take_last) state_q <= ST_MEAN;
				ST_MEAN: if (div_done) state_q <= ST_MSQ;
				ST_MSQ:  if (div_done) state_q <= ST_ROOT;
				ST_ROOT: if (sqrt_done) state_q <= ST_EMIT;
				ST_EMIT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the last sample's entry and the statistics as they finish
	always_ff @(posedge clk) begin
		if (take_last) begin
			k_min_x_q  <= h_min_x;
			k_max_x_q  <= h_max_x;
			k_min_y_q  <= h_min_y;
			k_max_y_q  <= h_max_y;
			k_count_q  <= h_count;
			k_ovf_q    <= h_ovf;
			k_neg_q    <= h_sum_y[SYW-1];
			k_sum_sq_q <= h_sum_sq;
		end
		if ((state_q == ST_MEAN) && div_done) begin
			k_mean_q <= k_neg_q ? -div_quo[SW-1:0] : div_quo[SW-1:0];
		end
		if (sqrt_done) begin
			k_rms_q <= sqrt_root;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_plain) begin
			o_min_x_q <= h_min_x;
			o_max_x_q <= h_max_x;
			o_min_y_q <= h_min_y;
			o_max_y_q <= h_max_y;
			o_count_q <= h_count;
			o_mean_q  <= '0;
			o_rms_q   <= '0;
			o_stats_q <= 1'b0;
			o_ovf_q   <= h_ovf;
		end else if (load_stats) begin
			o_min_x_q <= k_min_x_q;
			o_max_x_q <= k_max_x_q;
			o_min_y_q <= k_min_y_q;
			o_max_y_q <= k_max_y_q;
			o_count_q <= k_count_q;
			o_mean_q  <= k_mean_q;
			o_rms_q   <= k_rms_q;
			o_stats_q <= 1'b1;
			o_ovf_q   <= k_ovf_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_plain || load_stats) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.lowest_x       = o_min_x_q;
	assign results.highest_x      = o_max_x_q;
	assign results.lowest_y       = o_min_y_q;
	assign results.highest_y      = o_max_y_q;
	assign results.sample_count   = o_count_q;
	assign results.mean_y         = o_mean_q;
	assign results.rms_y          = o_rms_q;
	assign results.stats_ready    = o_stats_q;
	assign results.count_overflow = o_ovf_q;

endmodule

// ===== src/sample_statistics_accumulator.sv =====
// ----------------------------------------------------------------------------
// sample_statistics_accumulator
// Running min/max of x and y, sample count, mean and RMS of y per sample set.
// ----------------------------------------------------------------------------
// a sample that is not last passes the stage-1 register, the queue and the output register
// throughput: one sample per cycle while the queue and the result channel take them; the last
//   sample of a set is held in the back end for the shared one-bit-per-cycle divider
//   (mean, then mean square) and then the root unit
// a two-entry queue keeps samples flowing in while the last one is worked on, until it fills
// reset: asynchronous, clears counts, sums, flags and handshake state; no sweep
module sample_statistics_accumulator #(
	parameter int SAMPLE_WIDTH = ssa_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_SAMPLES  = ssa_pkg::MAX_SAMPLES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssa_in_if.sink    samples,
	ssa_out_if.source results
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SYW = SW + CW;
	localparam int SQW = 2 * SW + CW - 2;
	localparam int EW  = 4 * SW + CW + 2 + SYW + SQW;

	logic          push, full, pop, empty;
	logic [EW-1:0] push_data, pop_data;

	// front end: accept, extremes, squares, sums
	ssa_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	// decoupling queue
	ssa_queue #(
		.WIDTH(EW),
		.DEPTH(ssa_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	// back end: statistics and output register
	ssa_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_data(pop_data),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

	// a set that ends always has at least one counted sample
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.stats_ready |-> results.sample_count != '0)
		else $error("statistics result with zero count");

	// overflow only once the count has reached its bound
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.count_overflow |-> results.sample_count == CW'(MAX_SAMPLES))
		else $error("overflow flagged below the count bound");

	// mean and rms stay zero outside the last sample
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.stats_ready |-> results.mean_y == '0 && results.rms_y == '0)
		else $error("mean or rms set on a sample that is not last");

	// extremes stay ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.lowest_x <= results.highest_x
			&& results.lowest_y <= results.highest_y)
		else $error("minimum above maximum");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample statistics accumulator. Samples are
// streamed in sets closed by a last sample. A running model tracks extremes,
// count, sum and sum of squares and predicts one statistics record per sample,
// with mean and RMS on the last one. Every result transaction is compared with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int SW    = ssa_pkg::SAMPLE_WIDTH_DEF;
	localparam int LIMIT = ssa_pkg::MAX_SAMPLES_DEF;
	localparam int CW    = ssa_pkg::COUNT_WIDTH_DEF;

	// one statistics record as seen on the result channel
	typedef struct {
		logic signed [SW-1:0] lowest_x;
		logic signed [SW-1:0] highest_x;
		logic signed [SW-1:0] lowest_y;
		logic signed [SW-1:0] highest_y;
		logic [CW-1:0]        sample_count;
		logic signed [SW-1:0] mean_y;
		logic [SW-1:0]        rms_y;
		logic                 stats_ready;
		logic                 count_overflow;
	} stats_t;

	// running statistics of the current set and the records still owed
	class running_stats;
		logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
		int unsigned          n;
		longint               sum_y;
		longint               sum_sq;
		bit                   flagged;
		stats_t               expected_stats[$];
		int                   mismatches;

		function new();
			clear_set();
			mismatches = 0;
		endfunction

		function void clear_set();
			lo_x = '0;
			hi_x = '0;
			lo_y = '0;
			hi_y = '0;
			n = 0;
			sum_y = 0;
			sum_sq = 0;
			flagged = 1'b0;
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction

		// fold one accepted sample into the set and predict its record
		function void take_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
			logic last);
			stats_t want;
			longint msq;
			longint root;
			longint t;
			// first sample of a set loads the extremes
			if (n == 0) begin
				lo_x = x;
				hi_x = x;
				lo_y = y;
				hi_y = y;
			end else begin
				if (x < lo_x) lo_x = x;
				if (x > hi_x) hi_x = x;
				if (y < lo_y) lo_y = y;
				if (y > hi_y) hi_y = y;
			end
			// count saturates at the bound, the sample then stays out of the sums
			if (n >= LIMIT) begin
				flagged = 1'b1;
			end else begin
				n++;
				sum_y += y;
				sum_sq += longint'(y) * longint'(y);
			end
			want.lowest_x = lo_x;
			want.highest_x = hi_x;
			want.lowest_y = lo_y;
			want.highest_y = hi_y;
			want.sample_count = CW'(n);
			want.stats_ready = last;
			want.count_overflow = flagged;
			want.mean_y = '0;
			want.rms_y = '0;
			// mean truncates toward zero, rms is the floor root of the floored mean square
			if (last) begin
				want.mean_y = SW'(sum_y / longint'(n));
				msq = sum_sq / longint'(n);
				root = 0;
				for (int b = SW; b >= 0; b--) begin
					t = root | (longint'(1) << b);
					if (t * t <= msq) root = t;
				end
				want.rms_y = SW'(root);
			end
			expected_stats.push_back(want);
			if (last) clear_set();
		endfunction

		function void check_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// compare one result transaction with the oldest prediction
		function void compare_stats(stats_t got);
			stats_t want;
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result, expected none actual count %0d",
					$time, got.sample_count);
				mismatches++;
				return;
			end
			want = expected_stats.pop_front();
			check_field("lowest_x", want.lowest_x, got.lowest_x);
			check_field("highest_x", want.highest_x, got.highest_x);
			check_field("lowest_y", want.lowest_y, got.lowest_y);
			check_field("highest_y", want.highest_y, got.highest_y);
			check_field("sample_count", want.sample_count, got.sample_count);
			check_field("mean_y", want.mean_y, got.mean_y);
			check_field("rms_y", want.rms_y, got.rms_y);
			check_field("stats_ready", want.stats_ready, got.stats_ready);
			check_field("count_overflow", want.count_overflow, got.count_overflow);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet;
	int   gap_odds;

	running_stats book = new();

	ssa_in_if  sample_ch ();
	ssa_out_if stats_ch ();

	sample_statistics_accumulator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch.sink),
		.results (stats_ch.source)
	);

	// clock
	always #5 clk = ~clk;

	// result channel back-pressure in random bursts
	initial begin : stall_gen
		int stall_left;
		stats_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0) stats_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 18);
				stats_ch.ready <= 1'b0;
			end else begin
				stats_ch.ready <= 1'b1;
			end
		end
	end

	// capture each result transaction
	always @(posedge clk) begin
		stats_t got;
		if (arst_n && stats_ch.valid && stats_ch.ready) begin
			got.lowest_x = stats_ch.lowest_x;
			got.highest_x = stats_ch.highest_x;
			got.lowest_y = stats_ch.lowest_y;
			got.highest_y = stats_ch.highest_y;
			got.sample_count = stats_ch.sample_count;
			got.mean_y = stats_ch.mean_y;
			got.rms_y = stats_ch.rms_y;
			got.stats_ready = stats_ch.stats_ready;
			got.count_overflow = stats_ch.count_overflow;
			book.compare_stats(got);
		end
	end

	// often edge values, otherwise small values or anything
	function automatic logic signed [SW-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return -16'sd1;
			4: return 16'sd1;
			5: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// hold the sample channel idle for the number of cycles given
	task automatic pause_samples(input int cycles);
		sample_ch.valid <= 1'b0;
		sample_ch.sample_x <= 16'($urandom);
		sample_ch.sample_y <= 16'($urandom);
		sample_ch.last_sample <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// offer one sample and wait for its transaction
	task automatic send_sample(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
		input logic last);
		if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
			pause_samples($urandom_range(1, 18));
		sample_ch.valid <= 1'b1;
		sample_ch.sample_x <= x;
		sample_ch.sample_y <= y;
		sample_ch.last_sample <= last;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		book.take_sample(x, y, last);
	endtask

	// run limit
	initial begin
		#(10_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus
	initial begin
		int len;
		int sent;
		arst_n = 1'b0;
		quiet = 1'b0;
		gap_odds = 3;
		sample_ch.valid = 1'b0;
		sample_ch.sample_x = '0;
		sample_ch.sample_y = '0;
		sample_ch.last_sample = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample sets at the extremes
		send_sample(16'sh7fff, 16'sh8000, 1'b1);
		send_sample(16'sh8000, 16'sh7fff, 1'b1);
		send_sample(16'sh0000, 16'sh0000, 1'b1);
		// negative mean truncates toward zero
		send_sample(-16'sd5, -16'sd3, 1'b0);
		send_sample(16'sd7, -16'sd2, 1'b0);
		send_sample(16'sd1, 16'sd0, 1'b1);
		// positive mean of a set whose sum divides evenly
		send_sample(16'sd2, 16'sd5, 1'b0);
		send_sample(16'sd3, 16'sd0, 1'b0);
		send_sample(16'sd4, 16'sd1, 1'b1);
		// all positive and all negative sets, extremes never start from zero
		send_sample(16'sd300, 16'sd100, 1'b0);
		send_sample(16'sd100, 16'sd300, 1'b0);
		send_sample(16'sd200, 16'sd200, 1'b1);
		send_sample(-16'sd300, -16'sd100, 1'b0);
		send_sample(-16'sd100, -16'sd300, 1'b0);
		send_sample(-16'sd200, -16'sd200, 1'b1);
		// full-scale y for the widest mean and root
		send_sample(16'sh7fff, 16'sh8000, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 1'b0);
		send_sample(16'sh5555, 16'sh8000, 1'b1);
		send_sample(16'shaaaa, 16'sh7fff, 1'b0);
		send_sample(16'sh5555, 16'sh7fff, 1'b1);

		// random sets, rarely long, the tail without idling
		sent = 0;
		while (sent < 900) begin
			case ($urandom_range(0, 9))
				0, 1: len = 1;
				2: len = $urandom_range(40, 120);
				default: len = $urandom_range(2, 24);
			endcase
			gap_odds = $urandom_range(0, 6);
			quiet = (sent >= 760) || ($urandom_range(0, 5) == 0);
			for (int k = 0; k < len; k++) begin
				send_sample(pick_value(), pick_value(), k == len - 1);
				sent++;
			end
		end
		sample_ch.valid <= 1'b0;

		// drain, then let the back end settle
		while (book.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (book.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
